[src/nsf_pkg.sv]
// Package for the nibble shift framer: field widths, state and result types,
// and the set-bit count helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

    localparam int CMD_W   = 3;
    localparam int LEN_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int CNT_W   = 12;
    localparam int MAX_RES = 4;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    // Framer state carried from one data byte to the next
    typedef struct packed {
        logic [LEN_W-1:0] bytes_left;
        logic [NIB_W-1:0] held_nibble;
        logic [CNT_W-1:0] bit_count;
    } nsf_state_t;

    // One frame byte with its end-of-packet mark
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last;
    } nsf_res_t;

    // All frame bytes caused by one input transaction
    typedef struct packed {
        logic [RES_CNT_W-1:0]   count;
        nsf_res_t [MAX_RES-1:0] res;
    } nsf_batch_t;

    // Count the set bits of one byte
    function automatic logic [3:0] ones8(input logic [BYTE_W-1:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            c = c + {3'd0, v[i]};
        end
        return c;
    endfunction

endpackage : nsf_pkg

`default_nettype wire

[src/nsf_in_if.sv]
// Input channel of the framer: valid/ready handshake with one data byte
// and the header fields. Depends on nsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nsf_in_if;
    import nsf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output cmd, output length, output data_byte,
                    input ready);
    modport sink   (input valid, input cmd, input length, input data_byte,
                    output ready);
endinterface : nsf_in_if

`default_nettype wire

[src/nsf_out_if.sv]
// Output channel of the framer: valid/ready handshake with one frame byte.
// Depends on nsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nsf_out_if;
    import nsf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface : nsf_out_if

`default_nettype wire

[src/nsf_step.sv]
// Per-transaction framing logic: header, shifted data and trailer bytes,
// plus the next framer state. Depends on nsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsf_step
    import nsf_pkg::*;
(
    input  nsf_state_t        state,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [LEN_W-1:0]  length,
    input  logic [BYTE_W-1:0] data_byte,
    output nsf_state_t        state_next,
    output nsf_batch_t        batch
);

    logic [BYTE_W-1:0] hdr0;
    logic [BYTE_W-1:0] hdr1;
    logic [BYTE_W-1:0] shifted;
    logic [CNT_W-1:0]  sum;
    logic [CNT_W-1:0]  fin_sum;
    logic [LEN_W-1:0]  left;
    logic [NIB_W-1:0]  nib;
    nsf_res_t          trl0;
    nsf_res_t          trl1;

    // Candidate bytes for header and data
    assign hdr0    = {length[4:0], cmd};
    assign hdr1    = {data_byte[3:0], length[8:5]};
    assign shifted = {data_byte[3:0], state.held_nibble};
    assign nib     = data_byte[7:4];

    // Running count and remaining bytes after this transaction
    always_comb
    begin
        if (state.bytes_left == '0)
        begin
            sum  = {{(CNT_W-4){1'b0}}, ones8(hdr0)} + {{(CNT_W-4){1'b0}}, ones8(hdr1)};
            left = length - {{(LEN_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            sum  = state.bit_count + {{(CNT_W-4){1'b0}}, ones8(shifted)};
            left = state.bytes_left - {{(LEN_W-1){1'b0}}, 1'b1};
        end
    end

    // Trailer: fold in the final high nibble, then split the count
    assign fin_sum = sum + {{(CNT_W-4){1'b0}}, ones8({4'd0, nib})};
    assign trl0    = '{frame_byte: {fin_sum[3:0], nib}, last: 1'b0};
    assign trl1    = '{frame_byte: fin_sum[11:4], last: 1'b1};

    // Assemble result bytes and next state
    always_comb
    begin
        batch      = '0;
        state_next = state;
        if (state.bytes_left == '0)
        begin
            // Drop a first byte with zero length
            if (length != '0)
            begin
                batch.res[0] = '{frame_byte: hdr0, last: 1'b0};
                batch.res[1] = '{frame_byte: hdr1, last: 1'b0};
                if (left == '0)
                begin
                    batch.res[2] = trl0;
                    batch.res[3] = trl1;
                    batch.count  = RES_CNT_W'(4);
                    state_next   = '0;
                end
                else
                begin
                    batch.count = RES_CNT_W'(2);
                    state_next  = '{bytes_left: left, held_nibble: nib, bit_count: sum};
                end
            end
        end
        else
        begin
            batch.res[0] = '{frame_byte: shifted, last: 1'b0};
            if (left == '0)
            begin
                batch.res[1] = trl0;
                batch.res[2] = trl1;
                batch.count  = RES_CNT_W'(3);
                state_next   = '0;
            end
            else
            begin
                batch.count = RES_CNT_W'(1);
                state_next  = '{bytes_left: left, held_nibble: nib, bit_count: sum};
            end
        end
    end

endmodule : nsf_step

`default_nettype wire

[src/nibble_shift_framer.sv]
// Top level of the nibble shift framer: state registers, result buffer and
// handshakes. Depends on nsf_pkg, nsf_in_if, nsf_out_if and nsf_step.
//
//   channel | direction | payload                      | handshake
//   pkt     | in        | cmd, length, data_byte       | valid / ready
//   frame   | out       | frame_byte, last             | valid / ready
//
// A data byte is framed in the cycle it is taken; its frame bytes leave
// a four-entry result buffer with a single read port from the next cycle
// on, one per cycle while frame.ready is high. A middle byte yields one
// frame byte, a first byte two, a last byte three, a one-byte packet four.
// pkt.ready is high while the buffer is empty or its final entry is leaving.
// Reset clears the framer state and empties the buffer.
`timescale 1ns / 1ps
`default_nettype none

module nibble_shift_framer
    import nsf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    nsf_in_if.sink    pkt,
    nsf_out_if.source frame
);

    nsf_state_t           state_reg;
    nsf_state_t           state_next;
    nsf_batch_t           batch;
    nsf_res_t             res_reg  [MAX_RES];
    nsf_res_t             res_next [MAX_RES];
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] cnt_next;
    logic                 take;
    logic                 pop;

    nsf_step u_step (
        .state      (state_reg),
        .cmd        (pkt.cmd),
        .length     (pkt.length),
        .data_byte  (pkt.data_byte),
        .state_next (state_next),
        .batch      (batch)
    );

    // Handshakes
    assign pop   = frame.valid && frame.ready;
    assign pkt.ready = (cnt_reg == '0) ||
                       ((cnt_reg == RES_CNT_W'(1)) && frame.ready);
    assign take  = pkt.valid && pkt.ready;

    assign frame.valid      = (cnt_reg != '0);
    assign frame.frame_byte = res_reg[0].frame_byte;
    assign frame.last       = res_reg[0].last;

    // Load a new batch, or advance the buffer on each output transaction
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = res_reg[i];
        end
        if (take)
        begin
            cnt_next = batch.count;
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_next[i] = batch.res[i];
            end
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - RES_CNT_W'(1);
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

endmodule : nibble_shift_framer

`default_nettype wire

[tb/tb_nibble_shift_framer.sv]
// Self-checking testbench for nibble_shift_framer: random and directed packets
// against a cycle-free frame predictor. Depends on nsf_pkg, nsf_in_if,
// nsf_out_if and the nibble_shift_framer RTL.
`timescale 1ns / 1ps

module tb_nibble_shift_framer;
    import nsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_LEN       = 40;

    logic clk = 1'b0;
    logic rst_n;

    nsf_in_if  pkt_if ();
    nsf_out_if frame_if ();

    nibble_shift_framer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_if.sink),
        .frame (frame_if.source)
    );

    // Frame predictor state
    logic [LEN_W-1:0]  pend_bytes;
    logic [NIB_W-1:0]  carry_nib;
    logic [CNT_W-1:0]  ones_run;
    nsf_res_t          frame_expect_q[$];
    nsf_res_t          exp_frame;

    // Idle and stall settings, in percent
    int src_idle_pct;
    int sink_stall_pct;

    // Run statistics
    int mismatches;
    int frames_checked;
    int data_bytes_sent;
    int packets_sent;
    int empty_headers;
    int quiet_cycles;

    // Clock generation
    always #5 clk = ~clk;

    // Count the set bits of one byte
    function automatic logic [CNT_W-1:0] set_bits(input logic [BYTE_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

    // Work out the frame bytes caused by one accepted data byte
    task automatic frame_predict(input logic [CMD_W-1:0] c, input logic [LEN_W-1:0] l,
                                 input logic [BYTE_W-1:0] d);
        nsf_res_t r;
        r.last = 1'b0;
        if (pend_bytes == '0)
        begin
            // a first byte with zero length is dropped
            if (l == '0)
                return;
            r.frame_byte = {l[4:0], c};
            frame_expect_q.push_back(r);
            ones_run = set_bits(r.frame_byte);
            r.frame_byte = {d[3:0], l[8:5]};
            frame_expect_q.push_back(r);
            ones_run = ones_run + set_bits(r.frame_byte);
            pend_bytes = l - LEN_W'(1);
        end
        else
        begin
            r.frame_byte = {d[3:0], carry_nib};
            frame_expect_q.push_back(r);
            ones_run = ones_run + set_bits(r.frame_byte);
            pend_bytes = pend_bytes - LEN_W'(1);
        end
        carry_nib = d[7:4];
        // close the packet with the final nibble and the count
        if (pend_bytes == '0)
        begin
            ones_run = ones_run + set_bits({4'h0, carry_nib});
            r.frame_byte = {ones_run[3:0], carry_nib};
            frame_expect_q.push_back(r);
            r.frame_byte = ones_run[11:4];
            r.last = 1'b1;
            frame_expect_q.push_back(r);
            ones_run = '0;
            carry_nib = '0;
        end
    endtask

    // Send one data byte, idling first at random, and predict on acceptance
    task automatic send_byte(input logic [CMD_W-1:0] c, input logic [LEN_W-1:0] l,
                             input logic [BYTE_W-1:0] d);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pkt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_if.valid     <= 1'b1;
        pkt_if.cmd       <= c;
        pkt_if.length    <= l;
        pkt_if.data_byte <= d;
        @(posedge clk);
        while (!pkt_if.ready)
            @(posedge clk);
        if (pend_bytes == '0 && l == '0)
            empty_headers++;
        else
            data_bytes_sent++;
        if (pend_bytes == '0 && l != '0)
            packets_sent++;
        frame_predict(c, l, d);
    endtask

    // Pick a data byte, leaning towards the all-zero and all-one patterns
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Send a packet of random content; later bytes carry junk header fields
    task automatic send_rand_packet(input logic [LEN_W-1:0] l);
        send_byte(CMD_W'($urandom), l, pick_byte());
        for (int i = 1; i < l; i++)
        begin
            send_byte(CMD_W'($urandom), LEN_W'($urandom), pick_byte());
        end
    endtask

    // Field extremes, short packets and ignored header bytes
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // empty first byte, then single-byte packets at both extremes
        send_byte(3'd3, 9'd0, 8'hA5);
        send_byte(3'd0, 9'd1, 8'h00);
        send_byte(3'd7, 9'd1, 8'hFF);
        // later bytes ignore cmd and length, including a zero length
        send_byte(3'd5, 9'd2, 8'h0F);
        send_byte(3'd2, 9'd0, 8'hF0);
        send_byte(3'd6, 9'd3, 8'h5A);
        send_byte(3'd7, 9'd511, 8'hA5);
        send_byte(3'd0, 9'd0, 8'h3C);
        send_byte(3'd1, 9'd0, 8'h81);
        send_byte(3'd4, 9'd4, 8'h00);
        send_byte(3'd0, 9'd0, 8'hFF);
        send_byte(3'd0, 9'd0, 8'h80);
        send_byte(3'd0, 9'd0, 8'h01);
        send_byte(3'd2, 9'd1, 8'h96);
    endtask

    // Long packet of all ones: the set-bit count reaches the upper trailer byte
    task automatic test_long_ones();
        src_idle_pct   = 36;
        sink_stall_pct = 36;
        send_byte(3'd7, LEN_W'(LONG_LEN), 8'hFF);
        for (int i = 1; i < LONG_LEN; i++)
        begin
            send_byte(3'd7, 9'd511, 8'hFF);
        end
    endtask

    // Random packets with the given idle and stall rates
    task automatic test_random(input int idle_pct, input int stall_pct, input int n_bytes);
        int sent;
        int l;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_bytes)
        begin
            // drop in an empty first byte now and then
            if ($urandom_range(0, 9) == 0)
                send_byte(CMD_W'($urandom), 9'd0, pick_byte());
            case ($urandom_range(0, 19))
                0:          l = $urandom_range(17, 40);
                1, 2, 3, 4: l = $urandom_range(5, 16);
                default:    l = $urandom_range(1, 4);
            endcase
            send_rand_packet(LEN_W'(l));
            sent += l;
        end
    endtask

    // Let the last frame bytes drain, then report
    task automatic finish_run();
        src_idle_pct = 0;
        pkt_if.valid <= 1'b0;
        while (frame_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d packets with %0d data bytes and %0d empty headers,",
                 packets_sent, data_bytes_sent, empty_headers);
        $display("checking %0d frame bytes under four idle and stall patterns.",
                 frames_checked);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    endtask

    // Receiver: stall at random
    always @(posedge clk)
    begin
        frame_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Compare each accepted frame byte with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && frame_if.valid && frame_if.ready)
        begin
            if (frame_expect_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected frame byte %02h last %0b", $time,
                         frame_if.frame_byte, frame_if.last);
            end
            else
            begin
                exp_frame = frame_expect_q.pop_front();
                frames_checked++;
                if (frame_if.frame_byte !== exp_frame.frame_byte)
                begin
                    mismatches++;
                    $display("%0t: frame_byte expected %02h actual %02h", $time,
                             exp_frame.frame_byte, frame_if.frame_byte);
                end
                if (frame_if.last !== exp_frame.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b", $time,
                             exp_frame.last, frame_if.last);
                end
            end
        end
    end

    // Abort if no transaction moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (pkt_if.valid && pkt_if.ready) || (frame_if.valid && frame_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        rst_n            <= 1'b0;
        pkt_if.valid     <= 1'b0;
        pkt_if.cmd       <= '0;
        pkt_if.length    <= '0;
        pkt_if.data_byte <= '0;
        pend_bytes       = '0;
        carry_nib        = '0;
        ones_run         = '0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        mismatches       = 0;
        frames_checked   = 0;
        data_bytes_sent  = 0;
        packets_sent     = 0;
        empty_headers    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_ones();
        test_random(0, 0, 25);
        test_random(84, 0, 25);
        test_random(0, 84, 25);
        test_random(36, 36, 25);
        finish_run();
    end

endmodule : tb_nibble_shift_framer
